>>> rtl/c8ie_pkg.sv
// Shared types, constants and the font table for the CHIP-8 instruction executor.
package c8ie_pkg;

  localparam int MEM_DEPTH   = 4096;
  localparam int MEM_AW      = $clog2(MEM_DEPTH);
  localparam int STACK_DEPTH = 16;
  localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SP_W        = 5;
  localparam int REG_COUNT   = 16;
  localparam int REG_AW      = 4;
  localparam int FONT_BYTES  = 80;

  localparam logic [MEM_AW-1:0] PROGRAM_START = MEM_AW'(512);
  localparam logic [MEM_AW-1:0] FONT_BASE     = MEM_AW'(80);

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_STEP  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OVF    = 2'd1,
    ST_UNF    = 2'd2,
    ST_UNIMPL = 2'd3
  } status_t;

  // What an executed instruction still needs after the execute cycle.
  typedef enum logic [2:0] {
    K_PLAIN,
    K_FLAG,
    K_BCD,
    K_STORE,
    K_LOAD,
    K_FAULT
  } kind_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_DISP,
    S_RDCAP,
    S_F1,
    S_F2,
    S_RY,
    S_R0,
    S_V0,
    S_EXEC,
    S_FLAG,
    S_BCD,
    S_STR,
    S_STW,
    S_LDR,
    S_LDW,
    S_RESP
  } state_t;

  typedef struct packed {
    logic init_wr;
    logic lat_in;
    logic mem_rd_pc;
    logic mem_rd_pc1;
    logic mem_rd_addr;
    logic mem_wr_addr;
    logic cap_rd;
    logic cap_hi;
    logic cap_lo;
    logic rd_vx;
    logic rd_vy;
    logic rd_v0;
    logic cap_vx;
    logic cap_vy;
    logic cap_v0;
    logic exec;
    logic wr_flag;
    logic bcd_wr;
    logic blk_rd_reg;
    logic blk_wr_mem;
    logic blk_rd_mem;
    logic blk_wr_reg;
    logic cnt_clr;
    logic cnt_inc;
    logic ld_out;
  } cmd_t;

  typedef struct packed {
    func_t func;
    kind_t kind;
    logic  init_last;
    logic  blk_last;
    logic  bcd_last;
    logic  out_free;
  } sts_t;

  function automatic logic [7:0] font_byte(input logic [6:0] idx);
    logic [7:0] b;
    unique case (idx)
      7'd0:  b = 8'hF0; 7'd1:  b = 8'h90; 7'd2:  b = 8'h90; 7'd3:  b = 8'h90;
      7'd4:  b = 8'hF0; 7'd5:  b = 8'h20; 7'd6:  b = 8'h60; 7'd7:  b = 8'h20;
      7'd8:  b = 8'h20; 7'd9:  b = 8'h70; 7'd10: b = 8'hF0; 7'd11: b = 8'h10;
      7'd12: b = 8'hF0; 7'd13: b = 8'h80; 7'd14: b = 8'hF0; 7'd15: b = 8'hF0;
      7'd16: b = 8'h10; 7'd17: b = 8'hF0; 7'd18: b = 8'h10; 7'd19: b = 8'hF0;
      7'd20: b = 8'h90; 7'd21: b = 8'h90; 7'd22: b = 8'hF0; 7'd23: b = 8'h10;
      7'd24: b = 8'h10; 7'd25: b = 8'hF0; 7'd26: b = 8'h80; 7'd27: b = 8'hF0;
      7'd28: b = 8'h10; 7'd29: b = 8'hF0; 7'd30: b = 8'hF0; 7'd31: b = 8'h80;
      7'd32: b = 8'hF0; 7'd33: b = 8'h90; 7'd34: b = 8'hF0; 7'd35: b = 8'hF0;
      7'd36: b = 8'h10; 7'd37: b = 8'h20; 7'd38: b = 8'h40; 7'd39: b = 8'h40;
      7'd40: b = 8'hF0; 7'd41: b = 8'h90; 7'd42: b = 8'hF0; 7'd43: b = 8'h90;
      7'd44: b = 8'hF0; 7'd45: b = 8'hF0; 7'd46: b = 8'h90; 7'd47: b = 8'hF0;
      7'd48: b = 8'h10; 7'd49: b = 8'hF0; 7'd50: b = 8'hF0; 7'd51: b = 8'h90;
      7'd52: b = 8'hF0; 7'd53: b = 8'h90; 7'd54: b = 8'h90; 7'd55: b = 8'hE0;
      7'd56: b = 8'h90; 7'd57: b = 8'hE0; 7'd58: b = 8'h90; 7'd59: b = 8'hE0;
      7'd60: b = 8'hF0; 7'd61: b = 8'h80; 7'd62: b = 8'h80; 7'd63: b = 8'h80;
      7'd64: b = 8'hF0; 7'd65: b = 8'hE0; 7'd66: b = 8'h90; 7'd67: b = 8'h90;
      7'd68: b = 8'h90; 7'd69: b = 8'hE0; 7'd70: b = 8'hF0; 7'd71: b = 8'h80;
      7'd72: b = 8'hF0; 7'd73: b = 8'h80; 7'd74: b = 8'hF0; 7'd75: b = 8'hF0;
      7'd76: b = 8'h80; 7'd77: b = 8'hF0; 7'd78: b = 8'h80; 7'd79: b = 8'h80;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/c8ie_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module c8ie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/c8ie_ctrl.sv
// Sequencer for writes, reads and steps: fetch, operand read, execute and write-back.
module c8ie_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  c8ie_pkg::sts_t sts,
  output c8ie_pkg::cmd_t cmd
);
  import c8ie_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.lat_in  = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.func)
          FUNC_WRITE: begin
            cmd.mem_wr_addr = 1'b1;
            state_nxt       = S_RESP;
          end
          FUNC_READ: begin
            cmd.mem_rd_addr = 1'b1;
            state_nxt       = S_RDCAP;
          end
          FUNC_STEP: begin
            cmd.mem_rd_pc = 1'b1;
            state_nxt     = S_F1;
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_RDCAP: begin
        cmd.cap_rd = 1'b1;
        state_nxt  = S_RESP;
      end
      S_F1: begin
        cmd.mem_rd_pc1 = 1'b1;
        cmd.cap_hi     = 1'b1;
        state_nxt      = S_F2;
      end
      S_F2: begin
        cmd.cap_lo = 1'b1;
        cmd.rd_vx  = 1'b1;
        state_nxt  = S_RY;
      end
      S_RY: begin
        cmd.cap_vx = 1'b1;
        cmd.rd_vy  = 1'b1;
        state_nxt  = S_R0;
      end
      S_R0: begin
        cmd.cap_vy = 1'b1;
        cmd.rd_v0  = 1'b1;
        state_nxt  = S_V0;
      end
      S_V0: begin
        cmd.cap_v0 = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        unique case (sts.kind)
          K_FLAG:  state_nxt = S_FLAG;
          K_BCD:   state_nxt = S_BCD;
          K_STORE: state_nxt = S_STR;
          K_LOAD:  state_nxt = S_LDR;
          default: state_nxt = S_RESP;
        endcase
      end
      S_FLAG: begin
        cmd.wr_flag = 1'b1;
        state_nxt   = S_RESP;
      end
      S_BCD: begin
        cmd.bcd_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.bcd_last) begin
          state_nxt = S_RESP;
        end
      end
      S_STR: begin
        cmd.blk_rd_reg = 1'b1;
        state_nxt      = S_STW;
      end
      S_STW: begin
        cmd.blk_wr_mem = 1'b1;
        cmd.cnt_inc    = 1'b1;
        state_nxt      = sts.blk_last ? S_RESP : S_STR;
      end
      S_LDR: begin
        cmd.blk_rd_mem = 1'b1;
        state_nxt      = S_LDW;
      end
      S_LDW: begin
        cmd.blk_wr_reg = 1'b1;
        cmd.cnt_inc    = 1'b1;
        state_nxt      = sts.blk_last ? S_RESP : S_LDR;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

>>> rtl/c8ie_dp.sv
// Datapath: main memory, register file, stack, machine registers, decode and result register.
module c8ie_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  c8ie_pkg::cmd_t            cmd,
  output c8ie_pkg::sts_t            sts,
  input  logic [1:0]                in_func,
  input  logic [c8ie_pkg::MEM_AW-1:0] in_mem_addr,
  input  logic [7:0]                in_mem_data,
  input  logic [15:0]               in_keys_down,
  input  logic [7:0]                in_random_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_read_data,
  output logic [c8ie_pkg::MEM_AW-1:0] out_program_counter,
  output logic [15:0]               out_fetched_opcode,
  output logic [15:0]               out_index_value,
  output logic [7:0]                out_delay_value,
  output logic [7:0]                out_sound_value,
  output logic                      out_clear_screen,
  output logic [1:0]                out_status
);
  import c8ie_pkg::*;

  // Latched transaction.
  func_t             func_r;
  logic [MEM_AW-1:0] addr_r;
  logic [7:0]        wdat_r;
  logic [15:0]       keys_r;
  logic [7:0]        rnd_r;

  logic [15:0]       op_r;
  logic [7:0]        vx_r, vy_r, v0_r, rd_r, flag_r;
  logic [MEM_AW-1:0] pc_r;
  logic [15:0]       idx_r;
  logic [7:0]        dly_r, snd_r;
  logic [SP_W-1:0]   sp_r;
  logic [MEM_AW-1:0] stk_r [STACK_DEPTH];
  logic              clr_r;
  status_t           st_r;
  logic [MEM_AW-1:0] cnt_r;
  logic [REG_COUNT-1:0] vld_r;
  logic              rvld_r;
  logic              out_valid_r;

  // Main memory ports.
  logic              m_we;
  logic [MEM_AW-1:0] m_waddr, m_raddr, blk_addr, font_off;
  logic [7:0]        m_wdata, m_rdata, init_data;

  // Register file ports.
  logic              r_we;
  logic [REG_AW-1:0] r_waddr, r_raddr;
  logic [7:0]        r_wdata, r_rdata, r_val;

  // Decode results.
  kind_t             kind;
  status_t           st_c;
  logic [MEM_AW-1:0] npc, nxt_pc, skip_pc, nnn;
  logic [7:0]        kk, res, flg;
  logic              vx_we, push, pop, clr;
  logic [15:0]       idx_n;
  logic [7:0]        dly_n, snd_n;
  logic [SP_W-1:0]   sp_dec;
  logic              key_dn;

  // Decimal digits of Vx.
  logic [1:0]        bcd_h;
  logic [7:0]        bcd_rem;
  logic [14:0]       bcd_prod;
  logic [3:0]        bcd_t, bcd_u;
  logic [7:0]        bcd_dig;

  assign blk_addr = idx_r[MEM_AW-1:0] + cnt_r;
  assign font_off = cnt_r - FONT_BASE;
  assign init_data = (font_off < MEM_AW'(FONT_BYTES)) ? font_byte(font_off[6:0]) : 8'h00;
  assign r_val    = rvld_r ? r_rdata : 8'h00;

  always_comb begin
    bcd_h    = (vx_r >= 8'd200) ? 2'd2 : ((vx_r >= 8'd100) ? 2'd1 : 2'd0);
    bcd_rem  = vx_r - ((bcd_h == 2'd2) ? 8'd200 : ((bcd_h == 2'd1) ? 8'd100 : 8'd0));
    // Tens by reciprocal multiplication; exact for remainders below 100.
    bcd_prod = {7'd0, bcd_rem} * 15'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_u    = 4'(bcd_rem - {bcd_t, 3'b000} - {3'b000, bcd_t, 1'b0});
    case (cnt_r[1:0])
      2'd0:    bcd_dig = {6'd0, bcd_h};
      2'd1:    bcd_dig = {4'd0, bcd_t};
      default: bcd_dig = {4'd0, bcd_u};
    endcase
  end

  always_comb begin
    m_we    = 1'b0;
    m_waddr = cnt_r;
    m_wdata = init_data;
    if (cmd.init_wr) begin
      m_we = 1'b1;
    end else if (cmd.mem_wr_addr) begin
      m_we    = 1'b1;
      m_waddr = addr_r;
      m_wdata = wdat_r;
    end else if (cmd.bcd_wr) begin
      m_we    = 1'b1;
      m_waddr = blk_addr;
      m_wdata = bcd_dig;
    end else if (cmd.blk_wr_mem) begin
      m_we    = 1'b1;
      m_waddr = blk_addr;
      m_wdata = r_val;
    end
  end

  always_comb begin
    if (cmd.mem_rd_pc1) begin
      m_raddr = pc_r + MEM_AW'(1);
    end else if (cmd.mem_rd_addr) begin
      m_raddr = addr_r;
    end else if (cmd.blk_rd_mem) begin
      m_raddr = blk_addr;
    end else begin
      m_raddr = pc_r;
    end
  end

  c8ie_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  always_comb begin
    if (cmd.rd_vx) begin
      r_raddr = op_r[11:8];
    end else if (cmd.rd_vy) begin
      r_raddr = op_r[7:4];
    end else if (cmd.blk_rd_reg) begin
      r_raddr = cnt_r[REG_AW-1:0];
    end else begin
      r_raddr = '0;
    end
  end

  always_comb begin
    r_we    = 1'b0;
    r_waddr = op_r[11:8];
    r_wdata = res;
    if (cmd.exec && vx_we && st_c == ST_OK) begin
      r_we = 1'b1;
    end else if (cmd.wr_flag) begin
      r_we    = 1'b1;
      r_waddr = REG_AW'(REG_COUNT - 1);
      r_wdata = flag_r;
    end else if (cmd.blk_wr_reg) begin
      r_we    = 1'b1;
      r_waddr = cnt_r[REG_AW-1:0];
      r_wdata = m_rdata;
    end
  end

  c8ie_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_regs (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  // Instruction decode and execute.
  always_comb begin
    nxt_pc  = pc_r + MEM_AW'(2);
    skip_pc = pc_r + MEM_AW'(4);
    nnn     = op_r[11:0];
    kk      = op_r[7:0];
    sp_dec  = sp_r - SP_W'(1);
    key_dn  = (vx_r < 8'd16) && keys_r[vx_r[3:0]];
    kind    = K_PLAIN;
    st_c    = ST_OK;
    npc     = nxt_pc;
    vx_we   = 1'b0;
    res     = 8'h00;
    flg     = 8'h00;
    idx_n   = idx_r;
    dly_n   = dly_r;
    snd_n   = snd_r;
    push    = 1'b0;
    pop     = 1'b0;
    clr     = 1'b0;
    unique case (op_r[15:12])
      4'h0: begin
        if (op_r == 16'h00E0) begin
          clr = 1'b1;
        end else if (op_r == 16'h00EE) begin
          if (sp_r == '0) begin
            st_c = ST_UNF;
          end else begin
            pop = 1'b1;
            npc = stk_r[sp_dec[STK_AW-1:0]];
          end
        end else begin
          st_c = ST_UNIMPL;
        end
      end
      4'h1: npc = nnn;
      4'h2: begin
        if (sp_r >= SP_W'(STACK_DEPTH)) begin
          st_c = ST_OVF;
        end else begin
          push = 1'b1;
          npc  = nnn;
        end
      end
      4'h3: if (vx_r == kk) npc = skip_pc;
      4'h4: if (vx_r != kk) npc = skip_pc;
      4'h5: begin
        if (op_r[3:0] != 4'h0) st_c = ST_UNIMPL;
        else if (vx_r == vy_r) npc = skip_pc;
      end
      4'h6: begin
        vx_we = 1'b1;
        res   = kk;
      end
      4'h7: begin
        vx_we = 1'b1;
        res   = vx_r + kk;
      end
      4'h8: begin
        vx_we = 1'b1;
        kind  = K_FLAG;
        case (op_r[3:0])
          4'h0: begin res = vy_r;        kind = K_PLAIN; end
          4'h1: begin res = vx_r | vy_r; kind = K_PLAIN; end
          4'h2: begin res = vx_r & vy_r; kind = K_PLAIN; end
          4'h3: begin res = vx_r ^ vy_r; kind = K_PLAIN; end
          4'h4: {flg[0], res} = {1'b0, vx_r} + {1'b0, vy_r};
          4'h5: begin res = vx_r - vy_r; flg[0] = vx_r > vy_r; end
          4'h6: begin res = {1'b0, vx_r[7:1]}; flg[0] = vx_r[0]; end
          4'h7: begin res = vy_r - vx_r; flg[0] = vy_r > vx_r; end
          4'hE: begin res = {vx_r[6:0], 1'b0}; flg[0] = vx_r[7]; end
          default: begin
            vx_we = 1'b0;
            st_c  = ST_UNIMPL;
          end
        endcase
      end
      4'h9: begin
        if (op_r[3:0] != 4'h0) st_c = ST_UNIMPL;
        else if (vx_r != vy_r) npc = skip_pc;
      end
      4'hA: idx_n = {4'h0, nnn};
      4'hB: npc = nnn + {4'h0, v0_r};
      4'hC: begin
        vx_we = 1'b1;
        res   = rnd_r & kk;
      end
      4'hE: begin
        if (kk == 8'h9E) begin
          if (key_dn) npc = skip_pc;
        end else if (kk == 8'hA1) begin
          if (!key_dn) npc = skip_pc;
        end else begin
          st_c = ST_UNIMPL;
        end
      end
      4'hF: begin
        case (kk)
          8'h07: begin
            vx_we = 1'b1;
            res   = dly_r;
          end
          8'h15: dly_n = vx_r;
          8'h18: snd_n = vx_r;
          8'h1E: idx_n = idx_r + {8'h00, vx_r};
          8'h29: idx_n = {4'h0, FONT_BASE} + {6'd0, vx_r, 2'b00} + {8'h00, vx_r};
          8'h33: kind = K_BCD;
          8'h55: kind = K_STORE;
          8'h65: kind = K_LOAD;
          default: st_c = ST_UNIMPL;
        endcase
      end
      default: st_c = ST_UNIMPL;
    endcase
    if (st_c != ST_OK) begin
      kind  = K_FAULT;
      vx_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_in) begin
      func_r <= func_t'(in_func);
      addr_r <= in_mem_addr;
      wdat_r <= in_mem_data;
      keys_r <= in_keys_down;
      rnd_r  <= in_random_byte;
    end
    if (cmd.cap_rd) rd_r <= m_rdata;
    if (cmd.cap_hi) op_r[15:8] <= m_rdata;
    if (cmd.cap_lo) op_r[7:0] <= m_rdata;
    if (cmd.cap_vx) vx_r <= r_val;
    if (cmd.cap_vy) vy_r <= r_val;
    if (cmd.cap_v0) v0_r <= r_val;
    if (cmd.exec) begin
      st_r   <= st_c;
      clr_r  <= clr;
      flag_r <= flg;
      if (push) stk_r[sp_r[STK_AW-1:0]] <= nxt_pc;
    end
    if (cmd.ld_out) begin
      out_read_data       <= (func_r == FUNC_READ) ? rd_r : 8'h00;
      out_program_counter <= pc_r;
      out_fetched_opcode  <= (func_r == FUNC_STEP) ? op_r : 16'h0000;
      out_index_value     <= idx_r;
      out_delay_value     <= dly_r;
      out_sound_value     <= snd_r;
      out_clear_screen    <= (func_r == FUNC_STEP) && clr_r;
      out_status          <= (func_r == FUNC_STEP) ? st_r : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PROGRAM_START;
      idx_r       <= '0;
      dly_r       <= '0;
      snd_r       <= '0;
      sp_r        <= '0;
      cnt_r       <= '0;
      vld_r       <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rvld_r <= vld_r[r_raddr];
      if (r_we) vld_r[r_waddr] <= 1'b1;
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + MEM_AW'(1);
      end
      if (cmd.exec && st_c == ST_OK) begin
        pc_r  <= npc;
        idx_r <= idx_n;
        dly_r <= dly_n;
        snd_r <= snd_n;
        if (push) sp_r <= sp_r + SP_W'(1);
        else if (pop) sp_r <= sp_dec;
      end
      if (cmd.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.func      = func_r;
  assign sts.kind      = kind;
  assign sts.init_last = (cnt_r == MEM_AW'(MEM_DEPTH - 1));
  assign sts.blk_last  = (cnt_r[REG_AW-1:0] == op_r[11:8]);
  assign sts.bcd_last  = (cnt_r[1:0] == 2'd2);
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

>>> rtl/chip8_instruction_executor.sv
// CHIP-8 interpreter core: top level joining the sequencer and the datapath.
//
// Input channel (in_valid/in_ready): one transaction writes a memory byte,
// reads one, executes one instruction step or does nothing, chosen by in_func.
// Result channel (out_valid/out_ready): exactly one result per transaction,
// held in an output register until taken, showing the machine state after it.
// A memory write goes to the output register after dispatch, a read after a
// data capture, and an instruction step after fetch of two bytes, three
// register-file reads and execute. A flag-setting ALU step adds a flag write,
// BCD adds three digit writes, and Fx55/Fx65 add a read and a write per
// register moved, since main memory and the register file each have one read
// and one write port. After reset the block loads main memory with the font
// glyphs and zeros, one byte per cycle, with in_ready low; pc restarts at 0x200.
// A new transaction is taken while the previous result waits; if the receiver
// stalls, the finished work waits before the output register until it is free.
module chip8_instruction_executor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [11:0] in_mem_addr,
  input  logic [7:0]  in_mem_data,
  input  logic [15:0] in_keys_down,
  input  logic [7:0]  in_random_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [11:0] out_program_counter,
  output logic [15:0] out_fetched_opcode,
  output logic [15:0] out_index_value,
  output logic [7:0]  out_delay_value,
  output logic [7:0]  out_sound_value,
  output logic        out_clear_screen,
  output logic [1:0]  out_status
);
  import c8ie_pkg::*;

  cmd_t cmd;
  sts_t sts;

  c8ie_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  c8ie_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_func             (in_func),
    .in_mem_addr         (in_mem_addr),
    .in_mem_data         (in_mem_data),
    .in_keys_down        (in_keys_down),
    .in_random_byte      (in_random_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_read_data       (out_read_data),
    .out_program_counter (out_program_counter),
    .out_fetched_opcode  (out_fetched_opcode),
    .out_index_value     (out_index_value),
    .out_delay_value     (out_delay_value),
    .out_sound_value     (out_sound_value),
    .out_clear_screen    (out_clear_screen),
    .out_status          (out_status)
  );

endmodule

>>> rtl/c8ie_chk.sv
// Port-level checker for the CHIP-8 instruction executor and its bind.
module c8ie_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_read_data,
  input logic [15:0] out_fetched_opcode,
  input logic        out_clear_screen,
  input logic [1:0]  out_status
);
  import c8ie_pkg::*;

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // The core works on one transaction at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while the first is in progress");

  // A screen clear only ever comes from a successful 00E0.
  a_cls: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clear_screen |-> out_fetched_opcode == 16'h00E0 && out_status == ST_OK)
    else $error("clear screen without a successful CLS");

  // A read result carries no step information.
  a_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_data != 8'h00 |-> out_fetched_opcode == 16'h0000
      && out_status == ST_OK)
    else $error("read data mixed with a step result");

endmodule

bind chip8_instruction_executor c8ie_chk u_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_read_data      (out_read_data),
  .out_fetched_opcode (out_fetched_opcode),
  .out_clear_screen   (out_clear_screen),
  .out_status         (out_status)
);

>>> verif/chip8_instruction_executor_tb.sv
// Self-checking testbench for the CHIP-8 instruction executor, with its own execution predictor.
`timescale 1ns / 1ps

module chip8_instruction_executor_tb;
  import c8ie_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1600;

  typedef struct {
    logic [7:0]  rd;
    logic [11:0] pc;
    logic [15:0] op;
    logic [15:0] idx;
    logic [7:0]  dly;
    logic [7:0]  snd;
    logic        clr;
    status_t     st;
  } machine_view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = FUNC_NONE;
  logic [11:0] in_mem_addr = '0;
  logic [7:0]  in_mem_data = '0;
  logic [15:0] in_keys_down = '0;
  logic [7:0]  in_random_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_data;
  logic [11:0] out_program_counter;
  logic [15:0] out_fetched_opcode;
  logic [15:0] out_index_value;
  logic [7:0]  out_delay_value;
  logic [7:0]  out_sound_value;
  logic        out_clear_screen;
  logic [1:0]  out_status;

  chip8_instruction_executor dut (.*);

  always #5 clk = ~clk;

  // Predicted machine state.
  logic [7:0]  mem_img [MEM_DEPTH];
  logic [7:0]  vreg [16];
  logic [11:0] ret_stack [STACK_DEPTH];
  int          sp_reg;
  logic [11:0] prog_pc;
  logic [15:0] i_reg;
  logic [7:0]  dly_reg, snd_reg;

  machine_view_t pending_results[$];
  int errors = 0;
  int burst_left = 0;
  int n_steps = 0, n_faults = 0, n_clears = 0, n_checked = 0;

  const logic [7:0] glyphs [80] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  function automatic void reset_machine();
    for (int a = 0; a < MEM_DEPTH; a++) mem_img[a] = '0;
    for (int g = 0; g < 80; g++) mem_img[FONT_BASE + g] = glyphs[g];
    for (int r = 0; r < 16; r++) vreg[r] = '0;
    for (int s = 0; s < STACK_DEPTH; s++) ret_stack[s] = '0;
    sp_reg = 0;
    prog_pc = PROGRAM_START;
    i_reg = '0;
    dly_reg = '0;
    snd_reg = '0;
  endfunction

  // Executes one instruction on the predicted state; faults leave it untouched.
  function automatic status_t run_instruction(input logic [15:0] keys, input logic [7:0] rnd,
                                              output logic [15:0] op, output logic clr);
    logic [11:0] nxt, skp, new_pc, nnn;
    logic [3:0]  x, y, n;
    logic [7:0]  kk, vx, vy, res, flag;
    logic        has_flag, down;
    op = {mem_img[prog_pc], mem_img[prog_pc + 12'd1]};
    clr = 1'b0;
    nxt = prog_pc + 12'd2;
    skp = prog_pc + 12'd4;
    x = op[11:8];
    y = op[7:4];
    n = op[3:0];
    kk = op[7:0];
    nnn = op[11:0];
    vx = vreg[x];
    vy = vreg[y];
    new_pc = nxt;
    case (op[15:12])
      4'h0: begin
        if (op == 16'h00E0) clr = 1'b1;
        else if (op == 16'h00EE) begin
          if (sp_reg == 0) return ST_UNF;
          sp_reg--;
          new_pc = ret_stack[sp_reg];
          ret_stack[sp_reg] = '0;
        end else return ST_UNIMPL;
      end
      4'h1: new_pc = nnn;
      4'h2: begin
        if (sp_reg >= STACK_DEPTH) return ST_OVF;
        ret_stack[sp_reg] = nxt;
        sp_reg++;
        new_pc = nnn;
      end
      4'h3: if (vx == kk) new_pc = skp;
      4'h4: if (vx != kk) new_pc = skp;
      4'h5: begin
        if (n != 0) return ST_UNIMPL;
        if (vx == vy) new_pc = skp;
      end
      4'h6: vreg[x] = kk;
      4'h7: vreg[x] = vx + kk;
      4'h8: begin
        has_flag = 1'b1;
        flag = '0;
        case (n)
          4'h0: begin res = vy; has_flag = 1'b0; end
          4'h1: begin res = vx | vy; has_flag = 1'b0; end
          4'h2: begin res = vx & vy; has_flag = 1'b0; end
          4'h3: begin res = vx ^ vy; has_flag = 1'b0; end
          4'h4: begin res = vx + vy; flag = 8'({1'b0, vx} + {1'b0, vy} > 9'hFF); end
          4'h5: begin res = vx - vy; flag = 8'(vx > vy); end
          4'h6: begin res = vx >> 1; flag = 8'(vx[0]); end
          4'h7: begin res = vy - vx; flag = 8'(vy > vx); end
          4'hE: begin res = vx << 1; flag = 8'(vx[7]); end
          default: return ST_UNIMPL;
        endcase
        vreg[x] = res;
        // The flag is written last, so it wins when the destination is VF.
        if (has_flag) vreg[15] = flag;
      end
      4'h9: begin
        if (n != 0) return ST_UNIMPL;
        if (vx != vy) new_pc = skp;
      end
      4'hA: i_reg = {4'h0, nnn};
      4'hB: new_pc = nnn + {4'h0, vreg[0]};
      4'hC: vreg[x] = rnd & kk;
      4'hE: begin
        down = (vx < 16) && keys[vx[3:0]];
        if (kk == 8'h9E) begin
          if (down) new_pc = skp;
        end else if (kk == 8'hA1) begin
          if (!down) new_pc = skp;
        end else return ST_UNIMPL;
      end
      4'hF: begin
        case (kk)
          8'h07: vreg[x] = dly_reg;
          8'h15: dly_reg = vx;
          8'h18: snd_reg = vx;
          8'h1E: i_reg = i_reg + {8'h00, vx};
          8'h29: i_reg = 16'(FONT_BASE) + 16'd5 * {8'h00, vx};
          8'h33: begin
            mem_img[i_reg[11:0]] = 8'(vx / 100);
            mem_img[i_reg[11:0] + 12'd1] = 8'((vx / 10) % 10);
            mem_img[i_reg[11:0] + 12'd2] = 8'(vx % 10);
          end
          8'h55: for (int k = 0; k <= x; k++) mem_img[i_reg[11:0] + 12'(k)] = vreg[k];
          8'h65: for (int k = 0; k <= x; k++) vreg[k] = mem_img[i_reg[11:0] + 12'(k)];
          default: return ST_UNIMPL;
        endcase
      end
      default: return ST_UNIMPL;
    endcase
    prog_pc = new_pc;
    return ST_OK;
  endfunction

  function automatic machine_view_t predict_transaction(input logic [1:0] f,
      input logic [11:0] a, input logic [7:0] d, input logic [15:0] keys,
      input logic [7:0] rnd);
    machine_view_t v;
    v.rd = '0;
    v.op = '0;
    v.clr = 1'b0;
    v.st = ST_OK;
    if (f == FUNC_WRITE) mem_img[a] = d;
    else if (f == FUNC_READ) v.rd = mem_img[a];
    else if (f == FUNC_STEP) begin
      v.st = run_instruction(keys, rnd, v.op, v.clr);
      n_steps++;
      if (v.st != ST_OK) n_faults++;
      if (v.clr) n_clears++;
    end
    v.pc = prog_pc;
    v.idx = i_reg;
    v.dly = dly_reg;
    v.snd = snd_reg;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Sends one transaction, with bursts and random gaps in between.
  task automatic send_item(input logic [1:0] f, input logic [11:0] a, input logic [7:0] d);
    logic hit;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_mem_addr <= a;
    in_mem_data <= d;
    in_keys_down <= 16'($urandom);
    in_random_byte <= 8'($urandom);
    do begin
      @(negedge clk);
      hit = in_ready;
      @(posedge clk);
    end while (!hit);
    pending_results.push_back(predict_transaction(in_func, in_mem_addr, in_mem_data,
                                                  in_keys_down, in_random_byte));
    burst_left--;
  endtask

  // Places an opcode at the predicted pc and executes it.
  task automatic run_opcode(input logic [15:0] op);
    send_item(FUNC_WRITE, prog_pc, op[15:8]);
    send_item(FUNC_WRITE, prog_pc + 12'd1, op[7:0]);
    send_item(FUNC_STEP, 12'($urandom), 8'($urandom));
  endtask

  function automatic logic [15:0] random_opcode();
    logic [3:0] cls, x, y, n;
    logic [7:0] kk;
    logic [7:0] f_ops [8] = '{8'h07, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65};
    cls = 4'($urandom_range(0, 15));
    x = 4'($urandom);
    y = 4'($urandom);
    n = 4'($urandom);
    kk = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    case (cls)
      4'h0: case ($urandom_range(0, 3))
              0: return 16'h00E0;
              1, 2: return 16'h00EE;
              default: return {4'h0, 12'($urandom)};
            endcase
      4'h5, 4'h9: return {cls, x, y, ($urandom_range(0, 3) == 0) ? n : 4'h0};
      4'hE: case ($urandom_range(0, 4))
              0, 1: return {cls, x, 8'h9E};
              2, 3: return {cls, x, 8'hA1};
              default: return {cls, x, kk};
            endcase
      4'hF: return {cls, x, ($urandom_range(0, 5) == 0) ? kk : f_ops[$urandom_range(0, 7)]};
      4'h6, 4'h3, 4'h4, 4'h7, 4'hC: return {cls, x, kk};
      default: return {cls, x, y, n};
    endcase
  endfunction

  task automatic test_memory_access();
    send_item(FUNC_READ, FONT_BASE, 8'h00);
    send_item(FUNC_READ, FONT_BASE + 12'd79, 8'h00);
    send_item(FUNC_WRITE, 12'hFFF, 8'hFF);
    send_item(FUNC_READ, 12'hFFF, 8'h00);
    send_item(FUNC_WRITE, 12'h000, 8'h00);
    send_item(FUNC_READ, 12'h000, 8'hFF);
    send_item(FUNC_NONE, 12'hABC, 8'h5A);
  endtask

  task automatic test_corner_opcodes();
    run_opcode(16'h00E0);   // clear screen flag
    run_opcode(16'h00EE);   // return with an empty stack
    run_opcode(16'h6FFF);
    run_opcode(16'h8FF4);   // flag overwrites the sum in VF
    run_opcode(16'h1FFE);   // next fetch reads the last two bytes of memory
    run_opcode(16'hFF29);
    run_opcode(16'h0123);   // unimplemented
  endtask

  task automatic test_random_programs();
    int sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin send_item(FUNC_STEP, 12'($urandom), 8'($urandom)); sent++; end
        1: begin send_item(FUNC_READ, 12'($urandom), 8'($urandom)); sent++; end
        2: begin
          send_item(($urandom_range(0, 3) == 0) ? FUNC_NONE : FUNC_WRITE,
                    12'($urandom), 8'($urandom));
          sent++;
        end
        default: begin run_opcode(random_opcode()); sent += 3; end
      endcase
    end
  endtask

  // The receiver alternates between stretches of random stalls and full speed.
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 400;
    out_ready <= (stall_phase < 250) ? ($urandom_range(0, 2) != 0) : 1'b1;
  end

  always @(negedge clk) begin
    machine_view_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("result with no transaction waiting at %0t", $realtime);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_read_data !== want.rd) report_mismatch("read_data", out_read_data, want.rd);
        if (out_program_counter !== want.pc)
          report_mismatch("program_counter", out_program_counter, want.pc);
        if (out_fetched_opcode !== want.op)
          report_mismatch("fetched_opcode", out_fetched_opcode, want.op);
        if (out_index_value !== want.idx)
          report_mismatch("index_value", out_index_value, want.idx);
        if (out_delay_value !== want.dly)
          report_mismatch("delay_value", out_delay_value, want.dly);
        if (out_sound_value !== want.snd)
          report_mismatch("sound_value", out_sound_value, want.snd);
        if (out_clear_screen !== want.clr)
          report_mismatch("clear_screen", out_clear_screen, want.clr);
        if (out_status !== want.st) report_mismatch("status", out_status, want.st);
      end
    end
  end

  // Ends the run if nothing moves on either channel for too long.
  int idle_cycles = 0;
  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    reset_machine();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_memory_access();
    test_corner_opcodes();
    test_random_programs();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Checked %0d results: %0d instruction steps, %0d faults, %0d screen clears.",
             n_checked, n_steps, n_faults, n_clears);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
